### src/wws_pkg.sv
// wws_pkg: shared types and constants for the whole-word search block.
// Used by wws_cfg, wws_scan and whole_word_search. No dependencies.
package wws_pkg;

    localparam int DEF_MAX_PATTERN   = 32;
    localparam int DEF_COUNTER_WIDTH = 16;

    localparam int PAT_BYTES   = 32;
    localparam int PAT_IDX_W   = 5;
    localparam int PAT_LEN_W   = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_W       = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_LO     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_MID_LO = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_MID_HI = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_HI     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_LEN    = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'd32;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       new_file;
    } text_word_t;

    typedef struct packed {
        logic [OUT_W-1:0] line_number;
        logic [OUT_W-1:0] start_column;
    } hit_word_t;

    typedef struct packed {
        logic [PAT_BYTES*8-1:0] chars;
        logic [PAT_LEN_W-1:0]   length;
    } pattern_t;

endpackage

### src/whole_word_search.sv
// whole_word_search: top level; config bank, byte scanner and result register.
// Depends on wws_pkg, wws_cfg, wws_scan.
//
//  channel | handshake             | word / data
//  --------+-----------------------+------------------------------------
//  text    | text_valid/text_ready | text_word_t {text_byte, new_file}
//  hit     | hit_valid/hit_ready   | hit_word_t {line_number, start_column}
//  cfg     | cfg_we                | cfg_index, cfg_wdata (64 bit)
//
// One text word per cycle unless a hit is stalled; a word enters the input register, is
// compared and counted during the following cycle, and a hit then lands in the result
// register, which drives hit_valid.
// Reset clears all pattern registers, sets line to 1 and column to 0.
// A stalled hit holds only a word that hits; a non-hitting word still leaves the input register.
module whole_word_search #(
    parameter int MAX_PATTERN   = wws_pkg::DEF_MAX_PATTERN,
    parameter int COUNTER_WIDTH = wws_pkg::DEF_COUNTER_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            text_valid,
    output logic                            text_ready,
    input  wws_pkg::text_word_t             text,
    output logic                            hit_valid,
    input  logic                            hit_ready,
    output wws_pkg::hit_word_t              hit,
    input  logic                            cfg_we,
    input  logic [wws_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wws_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    wws_pkg::pattern_t  pattern;
    wws_pkg::hit_word_t res;
    logic               res_valid, res_ready;
    logic               hit_valid_reg;
    wws_pkg::hit_word_t hit_reg;

    wws_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pattern   (pattern)
    );

    wws_scan #(
        .MAX_PATTERN   (MAX_PATTERN),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text),
        .pattern    (pattern),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !hit_valid_reg || hit_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            hit_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            hit_reg <= res;
        end
    end

    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;

endmodule

### src/wws_cfg.sv
// wws_cfg: pattern register bank written through the plain write port.
// Depends on wws_pkg.
module wws_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [wws_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wws_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output wws_pkg::pattern_t                  pattern
);

    logic [wws_pkg::CFG_DATA_W-1:0] pat_lo_reg;
    logic [wws_pkg::CFG_DATA_W-1:0] pat_mid_lo_reg;
    logic [wws_pkg::CFG_DATA_W-1:0] pat_mid_hi_reg;
    logic [wws_pkg::CFG_DATA_W-1:0] pat_hi_reg;
    logic [wws_pkg::PAT_LEN_W-1:0]  pat_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg     <= '0;
            pat_mid_lo_reg <= '0;
            pat_mid_hi_reg <= '0;
            pat_hi_reg     <= '0;
            pat_len_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wws_pkg::CFG_PAT_LO:     pat_lo_reg     <= cfg_wdata;
                wws_pkg::CFG_PAT_MID_LO: pat_mid_lo_reg <= cfg_wdata;
                wws_pkg::CFG_PAT_MID_HI: pat_mid_hi_reg <= cfg_wdata;
                wws_pkg::CFG_PAT_HI:     pat_hi_reg     <= cfg_wdata;
                wws_pkg::CFG_PAT_LEN:    pat_len_reg    <= cfg_wdata[wws_pkg::PAT_LEN_W-1:0];
                default: ; // unknown index: write ignored
            endcase
        end
    end

    assign pattern.chars  = {pat_hi_reg, pat_mid_hi_reg, pat_mid_lo_reg, pat_lo_reg};
    assign pattern.length = pat_len_reg;

endmodule

### src/wws_scan.sv
// wws_scan: input register, word tracking state and the per-byte compare.
// Depends on wws_pkg; pattern comes from wws_cfg.
module wws_scan #(
    parameter int MAX_PATTERN   = wws_pkg::DEF_MAX_PATTERN,
    parameter int COUNTER_WIDTH = wws_pkg::DEF_COUNTER_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_ready,
    input  wws_pkg::text_word_t  text,
    input  wws_pkg::pattern_t    pattern,
    output logic                 res_valid,
    input  logic                 res_ready,
    output wws_pkg::hit_word_t   res
);

    localparam int WL_W = $clog2(MAX_PATTERN + 2);
    localparam logic [WL_W-1:0]          WL_MAX   = WL_W'(MAX_PATTERN);
    localparam logic [WL_W-1:0]          WL_OVER  = WL_W'(MAX_PATTERN + 1);
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE  = COUNTER_WIDTH'(1);

    logic                      a_valid_reg;
    wws_pkg::text_word_t       a_word_reg;

    logic [COUNTER_WIDTH-1:0]  line_reg, line_next;
    logic [COUNTER_WIDTH-1:0]  col_reg, col_next;
    logic [WL_W-1:0]           wl_reg, wl_next;
    logic                      eq_reg, eq_next;

    logic [COUNTER_WIDTH-1:0]  line_cur, col_cur;
    logic [WL_W-1:0]           wl_cur;
    logic                      eq_cur;
    logic [7:0]                b, folded, pat_ch;
    logic                      is_delim, match, advance;
    logic [COUNTER_WIDTH-1:0]  wl_ext, start_col;
    logic [wws_pkg::PAT_IDX_W-1:0] pat_idx;

    always_comb
    begin
        b = a_word_reg.text_byte;
        // new_file restarts tracking ahead of this byte
        if (a_word_reg.new_file)
        begin
            line_cur = CNT_ONE;
            col_cur  = '0;
            wl_cur   = '0;
            eq_cur   = 1'b1;
        end
        else
        begin
            line_cur = line_reg;
            col_cur  = col_reg;
            wl_cur   = wl_reg;
            eq_cur   = eq_reg;
        end

        is_delim = (b == wws_pkg::CH_SPACE) || (b == wws_pkg::CH_TAB) || (b == wws_pkg::CH_NL);
        folded   = (b >= wws_pkg::CH_UP_A && b <= wws_pkg::CH_UP_Z) ? b + wws_pkg::CASE_OFS : b;
        pat_idx  = wws_pkg::PAT_IDX_W'(wl_cur);
        pat_ch   = pattern.chars[pat_idx*8 +: 8];

        wl_ext    = COUNTER_WIDTH'(wl_cur);
        start_col = (col_cur >= wl_ext) ? col_cur - wl_ext : '0;

        match = is_delim && eq_cur && (wl_cur != '0) && (wl_cur <= WL_MAX)
                && (wws_pkg::PAT_LEN_W'(wl_cur) == pattern.length);

        line_next = line_cur;
        col_next  = (col_cur == '1) ? col_cur : col_cur + CNT_ONE;
        if (is_delim)
        begin
            wl_next = '0;
            eq_next = 1'b1;
            if (b == wws_pkg::CH_NL)
            begin
                line_next = (line_cur == '1) ? line_cur : line_cur + CNT_ONE;
                col_next  = '0;
            end
        end
        else if (wl_cur < WL_MAX)
        begin
            wl_next = wl_cur + WL_W'(1);
            eq_next = eq_cur && (folded == pat_ch);
        end
        else
        begin
            wl_next = WL_OVER;
            eq_next = 1'b0;
        end
    end

    // a byte without a hit leaves regardless of the result side
    assign advance    = a_valid_reg && (!match || res_ready);
    assign text_ready = !a_valid_reg || advance;
    assign res_valid  = a_valid_reg && match;
    assign res.line_number  = wws_pkg::OUT_W'(line_cur);
    assign res.start_column = wws_pkg::OUT_W'(start_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            line_reg    <= CNT_ONE;
            col_reg     <= '0;
            wl_reg      <= '0;
            eq_reg      <= 1'b1;
        end
        else
        begin
            if (text_ready)
            begin
                a_valid_reg <= text_valid;
            end
            if (advance)
            begin
                line_reg <= line_next;
                col_reg  <= col_next;
                wl_reg   <= wl_next;
                eq_reg   <= eq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            a_word_reg <= text;
        end
    end

    a_wl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wl_reg <= WL_OVER)
        else $error("word length past its cap");

    a_delim_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_delim) |=> (wl_reg == '0 && eq_reg))
        else $error("delimiter did not clear word tracking");

    a_restart_line: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && a_word_reg.new_file && b != wws_pkg::CH_NL) |=> (line_reg == CNT_ONE))
        else $error("new_file did not restart the line count");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !advance) |=> (a_valid_reg && $stable(line_reg) && $stable(col_reg)))
        else $error("state moved while the byte was held");

endmodule
